[design/amca_pkg.sv]
package amca_pkg;

  localparam int unsigned AxisW     = 16;
  localparam int unsigned MagW      = 16;
  localparam int unsigned ThrW      = 16;
  localparam int unsigned SumW      = 32;
  localparam int unsigned RemW      = MagW + 3;
  localparam int unsigned SqrtSteps = SumW / 2;
  localparam int unsigned IterW     = $clog2(SqrtSteps);
  localparam int unsigned FracBits  = 12;
  localparam int unsigned InDataW   = 3 * AxisW;
  localparam int unsigned OutDataW  = ((1 + MagW + 7) / 8) * 8;

  typedef enum logic [3:0] {
    StIdle,
    StMulX,
    StMulY,
    StMulZ,
    StAcc,
    StSqrt,
    StMulT,
    StCmp,
    StClr,
    StDone
  } amca_state_e;

  typedef enum logic [1:0] {
    MulX,
    MulY,
    MulZ,
    MulThr
  } amca_mul_sel_e;

  typedef struct packed {
    logic          load_in;
    logic          mul_en;
    amca_mul_sel_e mul_sel;
    logic          sum_load;
    logic          sum_acc;
    logic          sqrt_init;
    logic          sqrt_step;
    logic          compare;
    logic          clear;
    logic          out_load;
  } amca_cmd_t;

  typedef struct packed {
    logic sqrt_last;
  } amca_status_t;

endpackage

[design/accel_magnitude_change_alarm_unit.sv]
// Takes three signed 16-bit accelerometer axes per sample item, computes the magnitude as the
// floor square root of the sum of squares, and raises a sticky alarm when the change from the
// previous magnitude exceeds ratio_threshold/4096 of the current one; a clear item (tuser high)
// drops the alarm. Every item yields one result item with the alarm and the stored magnitude.
// A sample item runs the three squares, the 16-step two-bits-per-cycle square root loop, the
// threshold product and the compare; a clear item goes straight to its result. One item is
// worked on at a time; the next is taken while a result still waits in the output register.
module accel_magnitude_change_alarm_unit (
  input  logic                              clk_i,
  input  logic                              rst_ni,
  input  logic                              s_axis_tvalid,
  output logic                              s_axis_tready,
  input  logic [amca_pkg::InDataW-1:0]      s_axis_tdata,   // accel_x, accel_y, accel_z
  input  logic                              s_axis_tuser,   // operation
  output logic                              m_axis_tvalid,
  input  logic                              m_axis_tready,
  output logic [amca_pkg::OutDataW-1:0]     m_axis_tdata,   // alarm, magnitude, zero fill
  input  logic                              cfg_we_i,
  input  logic [amca_pkg::ThrW-1:0]         cfg_wdata_i
);

  amca_pkg::amca_cmd_t    cmd;
  amca_pkg::amca_status_t status;

  amca_ctrl u_ctrl (
    .clk_i       (clk_i),
    .rst_ni      (rst_ni),
    .in_valid_i  (s_axis_tvalid),
    .in_clear_i  (s_axis_tuser),
    .in_ready_o  (s_axis_tready),
    .out_valid_o (m_axis_tvalid),
    .out_ready_i (m_axis_tready),
    .status_i    (status),
    .cmd_o       (cmd)
  );

  amca_dp u_dp (
    .clk_i       (clk_i),
    .rst_ni      (rst_ni),
    .in_data_i   (s_axis_tdata),
    .cfg_we_i    (cfg_we_i),
    .cfg_wdata_i (cfg_wdata_i),
    .cmd_i       (cmd),
    .status_o    (status),
    .out_data_o  (m_axis_tdata)
  );

endmodule

[design/amca_ctrl.sv]
module amca_ctrl (
  input  logic                   clk_i,
  input  logic                   rst_ni,
  input  logic                   in_valid_i,
  input  logic                   in_clear_i,
  output logic                   in_ready_o,
  output logic                   out_valid_o,
  input  logic                   out_ready_i,
  input  amca_pkg::amca_status_t status_i,
  output amca_pkg::amca_cmd_t    cmd_o
);

  amca_pkg::amca_state_e state_q, state_d;
  logic                  out_valid_q, out_valid_d;
  logic                  out_free;

  assign out_free    = !out_valid_q || out_ready_i;
  assign in_ready_o  = (state_q == amca_pkg::StIdle);
  assign out_valid_o = out_valid_q;

  always_comb begin
    state_d = state_q;
    unique case (state_q)
      amca_pkg::StIdle: begin
        if (in_valid_i) begin
          state_d = in_clear_i ? amca_pkg::StClr : amca_pkg::StMulX;
        end
      end
      amca_pkg::StMulX: state_d = amca_pkg::StMulY;
      amca_pkg::StMulY: state_d = amca_pkg::StMulZ;
      amca_pkg::StMulZ: state_d = amca_pkg::StAcc;
      amca_pkg::StAcc:  state_d = amca_pkg::StSqrt;
      amca_pkg::StSqrt: begin
        if (status_i.sqrt_last) begin
          state_d = amca_pkg::StMulT;
        end
      end
      amca_pkg::StMulT: state_d = amca_pkg::StCmp;
      amca_pkg::StCmp:  state_d = amca_pkg::StDone;
      amca_pkg::StClr:  state_d = amca_pkg::StDone;
      amca_pkg::StDone: begin
        if (out_free) begin
          state_d = amca_pkg::StIdle;
        end
      end
      default: state_d = amca_pkg::StIdle;
    endcase
  end

  always_comb begin
    cmd_o         = '0;
    cmd_o.mul_sel = amca_pkg::MulX;
    unique case (state_q)
      amca_pkg::StIdle: cmd_o.load_in = in_valid_i;
      amca_pkg::StMulX: begin
        cmd_o.mul_en  = 1'b1;
        cmd_o.mul_sel = amca_pkg::MulX;
      end
      amca_pkg::StMulY: begin
        cmd_o.mul_en   = 1'b1;
        cmd_o.mul_sel  = amca_pkg::MulY;
        cmd_o.sum_load = 1'b1;
      end
      amca_pkg::StMulZ: begin
        cmd_o.mul_en  = 1'b1;
        cmd_o.mul_sel = amca_pkg::MulZ;
        cmd_o.sum_acc = 1'b1;
      end
      amca_pkg::StAcc:  cmd_o.sqrt_init = 1'b1;
      amca_pkg::StSqrt: cmd_o.sqrt_step = 1'b1;
      amca_pkg::StMulT: begin
        cmd_o.mul_en  = 1'b1;
        cmd_o.mul_sel = amca_pkg::MulThr;
      end
      amca_pkg::StCmp:  cmd_o.compare = 1'b1;
      amca_pkg::StClr:  cmd_o.clear = 1'b1;
      amca_pkg::StDone: cmd_o.out_load = out_free;
      default: ;
    endcase
  end

  always_comb begin
    out_valid_d = out_valid_q;
    if (cmd_o.out_load) begin
      out_valid_d = 1'b1;
    end else if (out_ready_i) begin
      out_valid_d = 1'b0;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q     <= amca_pkg::StIdle;
      out_valid_q <= 1'b0;
    end else begin
      state_q     <= state_d;
      out_valid_q <= out_valid_d;
    end
  end

endmodule

[design/amca_dp.sv]
module amca_dp (
  input  logic                              clk_i,
  input  logic                              rst_ni,
  input  logic [amca_pkg::InDataW-1:0]      in_data_i,
  input  logic                              cfg_we_i,
  input  logic [amca_pkg::ThrW-1:0]         cfg_wdata_i,
  input  amca_pkg::amca_cmd_t               cmd_i,
  output amca_pkg::amca_status_t            status_o,
  output logic [amca_pkg::OutDataW-1:0]     out_data_o
);

  localparam int unsigned AW = amca_pkg::AxisW;
  localparam int unsigned MW = amca_pkg::MagW;
  localparam int unsigned SW = amca_pkg::SumW;
  localparam int unsigned RW = amca_pkg::RemW;

  logic [amca_pkg::ThrW-1:0]  thr_q;
  logic [AW-1:0]              ax_q, ay_q, az_q;
  logic [SW-1:0]              prod_q, sum_q, rad_q;
  logic [RW-1:0]              rem_q;
  logic [MW-1:0]              root_q, prev_q;
  logic [amca_pkg::IterW-1:0] iter_q;
  logic                       alarm_q;
  logic                       out_alarm_q;
  logic [MW-1:0]              out_mag_q;

  logic [AW-1:0] mul_a, mul_b;
  logic [SW-1:0] mul_p;
  logic [RW-1:0] rem_sh, trial;
  logic          fits;
  logic [MW-1:0] diff;
  logic [SW-1:0] diff_scaled;
  logic          trip;

  function automatic logic [AW-1:0] abs16(input logic [AW-1:0] v);
    abs16 = v[AW-1] ? (~v + AW'(1)) : v;
  endfunction

  always_comb begin
    unique case (cmd_i.mul_sel)
      amca_pkg::MulX: begin
        mul_a = ax_q;
        mul_b = ax_q;
      end
      amca_pkg::MulY: begin
        mul_a = ay_q;
        mul_b = ay_q;
      end
      amca_pkg::MulZ: begin
        mul_a = az_q;
        mul_b = az_q;
      end
      amca_pkg::MulThr: begin
        mul_a = thr_q;
        mul_b = root_q;
      end
      default: begin
        mul_a = '0;
        mul_b = '0;
      end
    endcase
  end

  assign mul_p = mul_a * mul_b;

  assign rem_sh = {rem_q[RW-3:0], rad_q[SW-1 -: 2]};
  assign trial  = RW'({root_q, 2'b01});
  assign fits   = (rem_sh >= trial);

  assign diff        = (prev_q >= root_q) ? (prev_q - root_q) : (root_q - prev_q);
  assign diff_scaled = SW'({diff, {amca_pkg::FracBits{1'b0}}});
  assign trip        = (prev_q != '0) && (diff_scaled > prod_q);

  assign status_o.sqrt_last = (iter_q == amca_pkg::IterW'(amca_pkg::SqrtSteps - 1));

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      thr_q   <= '0;
      prev_q  <= '0;
      alarm_q <= 1'b0;
    end else begin
      if (cfg_we_i) begin
        thr_q <= cfg_wdata_i;
      end
      if (cmd_i.compare) begin
        prev_q <= root_q;
        if (trip) begin
          alarm_q <= 1'b1;
        end
      end else if (cmd_i.clear) begin
        alarm_q <= 1'b0;
      end
    end
  end

  always_ff @(posedge clk_i) begin
    if (cmd_i.load_in) begin
      ax_q <= abs16(in_data_i[0*AW +: AW]);
      ay_q <= abs16(in_data_i[1*AW +: AW]);
      az_q <= abs16(in_data_i[2*AW +: AW]);
    end
    if (cmd_i.mul_en) begin
      prod_q <= mul_p;
    end
    if (cmd_i.sum_load) begin
      sum_q <= prod_q;
    end else if (cmd_i.sum_acc) begin
      sum_q <= sum_q + prod_q;
    end
    if (cmd_i.sqrt_init) begin
      rad_q  <= sum_q + prod_q;
      rem_q  <= '0;
      root_q <= '0;
      iter_q <= '0;
    end else if (cmd_i.sqrt_step) begin
      rad_q  <= {rad_q[SW-3:0], 2'b00};
      rem_q  <= fits ? (rem_sh - trial) : rem_sh;
      root_q <= {root_q[MW-2:0], fits};
      iter_q <= iter_q + 1'b1;
    end
    if (cmd_i.out_load) begin
      out_alarm_q <= alarm_q;
      out_mag_q   <= prev_q;
    end
  end

  assign out_data_o = amca_pkg::OutDataW'({out_mag_q, out_alarm_q});

endmodule

[design/amca_checker.sv]
module amca_checker (
  input logic                          clk_i,
  input logic                          rst_ni,
  input logic                          s_axis_tvalid,
  input logic                          s_axis_tready,
  input logic                          m_axis_tvalid,
  input logic                          m_axis_tready,
  input logic [amca_pkg::OutDataW-1:0] m_axis_tdata
);

  logic in_acc;

  assign in_acc = s_axis_tvalid && s_axis_tready;

  a_out_hold: assert property (@(posedge clk_i) disable iff (!rst_ni)
    m_axis_tvalid && !m_axis_tready |=> m_axis_tvalid)
    else $error("result item dropped while stalled");

  a_one_at_a_time: assert property (@(posedge clk_i) disable iff (!rst_ni)
    in_acc |=> !s_axis_tready)
    else $error("second item taken while one is in work");

  a_no_instant_result: assert property (@(posedge clk_i) disable iff (!rst_ni)
    $rose(m_axis_tvalid) |-> !$past(in_acc))
    else $error("result appeared right after acceptance");

  a_mag_range: assert property (@(posedge clk_i) disable iff (!rst_ni)
    m_axis_tvalid |-> (m_axis_tdata[amca_pkg::MagW:1] <= amca_pkg::MagW'(56755)))
    else $error("magnitude out of range");

endmodule

bind accel_magnitude_change_alarm_unit amca_checker u_amca_checker (
  .clk_i         (clk_i),
  .rst_ni        (rst_ni),
  .s_axis_tvalid (s_axis_tvalid),
  .s_axis_tready (s_axis_tready),
  .m_axis_tvalid (m_axis_tvalid),
  .m_axis_tready (m_axis_tready),
  .m_axis_tdata  (m_axis_tdata)
);

[verif/tb_accel_magnitude_change_alarm_unit.sv]
`timescale 1ns / 100ps

module tb_accel_magnitude_change_alarm_unit;

  typedef enum logic {
    OpSample = 1'b0,
    OpClear  = 1'b1
  } accel_op_e;

  typedef struct {
    accel_op_e                  op;
    logic [amca_pkg::AxisW-1:0] x;
    logic [amca_pkg::AxisW-1:0] y;
    logic [amca_pkg::AxisW-1:0] z;
  } accel_item_t;

  typedef struct {
    logic                      alarm;
    logic [amca_pkg::MagW-1:0] mag;
  } alarm_reading_t;

  logic                          clk_i         = 1'b0;
  logic                          rst_ni        = 1'b0;
  logic                          s_axis_tvalid = 1'b0;
  logic                          s_axis_tready;
  logic [amca_pkg::InDataW-1:0]  s_axis_tdata  = '0;  // accel_x, accel_y, accel_z
  logic                          s_axis_tuser  = 1'b0;  // operation
  logic                          m_axis_tvalid;
  logic                          m_axis_tready = 1'b0;
  logic [amca_pkg::OutDataW-1:0] m_axis_tdata;  // alarm, magnitude, zero fill
  logic                          cfg_we_i      = 1'b0;
  logic [amca_pkg::ThrW-1:0]     cfg_wdata_i   = '0;

  accel_item_t    accel_q[$];
  alarm_reading_t reading_q[$];
  accel_item_t    drive_item;

  logic [amca_pkg::MagW-1:0] stored_mag = '0;
  logic                      alarm_flag = 1'b0;
  logic [amca_pkg::ThrW-1:0] ratio_thr  = '0;

  int send_wait = 0;
  int recv_wait = 0;
  bit no_idle   = 1'b0;
  int n_pushed  = 0;
  int n_seen    = 0;
  int n_samples = 0;
  int n_clears  = 0;
  int n_alarms  = 0;
  int n_thr     = 0;
  int errors    = 0;
  int base_x    = 1000;
  int base_y    = -2000;
  int base_z    = 16000;

  accel_magnitude_change_alarm_unit dut (
    .clk_i        (clk_i),
    .rst_ni       (rst_ni),
    .s_axis_tvalid(s_axis_tvalid),
    .s_axis_tready(s_axis_tready),
    .s_axis_tdata (s_axis_tdata),
    .s_axis_tuser (s_axis_tuser),
    .m_axis_tvalid(m_axis_tvalid),
    .m_axis_tready(m_axis_tready),
    .m_axis_tdata (m_axis_tdata),
    .cfg_we_i     (cfg_we_i),
    .cfg_wdata_i  (cfg_wdata_i)
  );

  always begin
    #5 clk_i = 1'b1;
    #5 clk_i = 1'b0;
  end

  function automatic int draw_wait();
    return no_idle ? 0 : int'($urandom_range(0, 13));
  endfunction

  function automatic logic [amca_pkg::MagW-1:0] floor_root(logic [31:0] n);
    logic [amca_pkg::MagW-1:0] r;
    logic [amca_pkg::MagW-1:0] t;
    r = '0;
    for (int b = amca_pkg::MagW - 1; b >= 0; b--) begin
      t = r | (amca_pkg::MagW'(1) << b);
      if (longint'(t) * longint'(t) <= longint'(n)) r = t;
    end
    return r;
  endfunction

  function automatic longint axis_square(logic [amca_pkg::AxisW-1:0] a);
    longint s;
    s = longint'($signed(a));
    return s * s;
  endfunction

  task automatic predict_alarm_reading(accel_item_t it);
    alarm_reading_t            r;
    logic [31:0]               sum;
    logic [amca_pkg::MagW-1:0] cur;
    longint unsigned           diff;
    if (it.op == OpClear) begin
      alarm_flag = 1'b0;
    end else begin
      sum = 32'(axis_square(it.x) + axis_square(it.y) + axis_square(it.z));
      cur = floor_root(sum);
      if (stored_mag != '0) begin
        diff = (stored_mag > cur) ? longint'(stored_mag) - longint'(cur)
                                  : longint'(cur) - longint'(stored_mag);
        if ((diff << amca_pkg::FracBits) > longint'(ratio_thr) * longint'(cur)) begin
          alarm_flag = 1'b1;
        end
      end
      stored_mag = cur;
    end
    r.alarm = alarm_flag;
    r.mag   = stored_mag;
    reading_q.push_back(r);
  endtask

  always @(posedge clk_i) begin
    if (!rst_ni) begin
      s_axis_tvalid <= 1'b0;
      send_wait = draw_wait();
    end else begin
      if (s_axis_tvalid && s_axis_tready) begin
        predict_alarm_reading(drive_item);
        send_wait = draw_wait();
      end
      if (!s_axis_tvalid || s_axis_tready) begin
        if (send_wait > 0) begin
          send_wait--;
          s_axis_tvalid <= 1'b0;
        end else if (accel_q.size() > 0) begin
          drive_item = accel_q.pop_front();
          s_axis_tvalid <= 1'b1;
          s_axis_tuser  <= drive_item.op;
          s_axis_tdata  <= {drive_item.z, drive_item.y, drive_item.x};
        end else begin
          s_axis_tvalid <= 1'b0;
        end
      end
    end
  end

  always @(posedge clk_i) begin
    alarm_reading_t want;
    if (!rst_ni) begin
      m_axis_tready <= 1'b0;
      recv_wait = draw_wait();
    end else begin
      if (m_axis_tvalid && m_axis_tready) begin
        n_seen++;
        if (reading_q.size() == 0) begin
          $error("unexpected result: alarm %0d, magnitude %0d", m_axis_tdata[0],
                 m_axis_tdata[amca_pkg::MagW:1]);
          errors++;
        end else begin
          want = reading_q.pop_front();
          if (m_axis_tdata[0] !== want.alarm) begin
            $error("alarm: expected %0d, actual %0d", want.alarm, m_axis_tdata[0]);
            errors++;
          end
          if (m_axis_tdata[amca_pkg::MagW:1] !== want.mag) begin
            $error("magnitude: expected %0d, actual %0d", want.mag,
                   m_axis_tdata[amca_pkg::MagW:1]);
            errors++;
          end
          if (want.alarm) n_alarms++;
        end
        recv_wait = draw_wait();
      end
      if (recv_wait > 0) begin
        recv_wait--;
        m_axis_tready <= 1'b0;
      end else begin
        m_axis_tready <= 1'b1;
      end
    end
  end

  task automatic push_item(accel_op_e op, int x, int y, int z);
    accel_item_t it;
    it.op = op;
    it.x  = amca_pkg::AxisW'(x);
    it.y  = amca_pkg::AxisW'(y);
    it.z  = amca_pkg::AxisW'(z);
    accel_q.push_back(it);
    n_pushed++;
    if (op == OpClear) n_clears++;
    else n_samples++;
  endtask

  task automatic drain();
    while (n_seen != n_pushed) @(posedge clk_i);
  endtask

  task automatic write_threshold(logic [amca_pkg::ThrW-1:0] v);
    drain();
    @(posedge clk_i);
    cfg_we_i    <= 1'b1;
    cfg_wdata_i <= v;
    @(posedge clk_i);
    cfg_we_i <= 1'b0;
    ratio_thr = v;
    n_thr++;
  endtask

  task automatic random_item();
    int k;
    int span;
    k = $urandom_range(0, 99);
    if (k < 8) begin
      push_item(OpClear, $urandom, $urandom, $urandom);
    end else if (k < 20) begin
      base_x = $signed(amca_pkg::AxisW'($urandom));
      base_y = $signed(amca_pkg::AxisW'($urandom));
      base_z = $signed(amca_pkg::AxisW'($urandom));
      push_item(OpSample, base_x, base_y, base_z);
    end else if (k < 23) begin
      push_item(OpSample, 0, 0, 0);
    end else if (k < 25) begin
      push_item(OpSample, -32768, -32768, -32768);
    end else begin
      case ($urandom_range(0, 2))
        0:       span = 2;
        1:       span = 40;
        default: span = 600;
      endcase
      push_item(OpSample, base_x + int'($urandom_range(0, 2 * span)) - span,
                base_y + int'($urandom_range(0, 2 * span)) - span,
                base_z + int'($urandom_range(0, 2 * span)) - span);
    end
  endtask

  initial begin
    logic [amca_pkg::ThrW-1:0] thr_list[5];
    thr_list = '{16'd4096, 16'd410, 16'd16, 16'hFFFF, 16'd0};
    thr_list[4] = amca_pkg::ThrW'($urandom);
    repeat (9) @(posedge clk_i);
    rst_ni <= 1'b1;

    write_threshold('0);
    push_item(OpSample, 3000, 4000, 0);
    push_item(OpSample, 0, 3000, 4000);
    push_item(OpSample, 3010, 4000, 0);
    push_item(OpClear, -1, 32767, -32768);
    push_item(OpSample, -32768, -32768, -32768);
    push_item(OpClear, 0, 0, 0);
    push_item(OpSample, 32767, 32767, 32767);
    push_item(OpClear, 0, 0, 0);
    push_item(OpSample, 0, 0, 0);
    push_item(OpSample, -32768, 0, 0);
    push_item(OpClear, 0, 0, 0);
    push_item(OpSample, 0, -32768, 0);
    push_item(OpSample, 0, 0, 1);
    push_item(OpClear, 0, 0, 0);
    push_item(OpSample, 0, 0, 0);
    push_item(OpSample, 1, 1, 1);

    write_threshold(16'hFFFF);
    push_item(OpSample, 0, 0, 16);
    push_item(OpSample, 0, 0, 1);
    push_item(OpSample, 0, 0, 0);
    push_item(OpClear, 0, 0, 0);
    push_item(OpSample, -32768, -32768, -32768);
    push_item(OpSample, 0, 0, 1);

    for (int p = 0; p < 5; p++) begin
      write_threshold(thr_list[p]);
      for (int i = 0; i < 80; i++) begin
        if (i % 20 == 0) no_idle = ($urandom_range(0, 3) == 0);
        if (p == 1 && i == 40) drain();
        random_item();
      end
    end

    drain();
    repeat (40) @(posedge clk_i);
    if (reading_q.size() != 0) errors++;
    $display("Run covered %0d sample items and %0d clear items over %0d threshold writes,",
             n_samples, n_clears, n_thr);
    $display("with the alarm raised in %0d of %0d results.", n_alarms, n_seen);
    if (errors == 0) begin
      $display("tb_accel_magnitude_change_alarm_unit OK");
    end else begin
      $display("tb_accel_magnitude_change_alarm_unit NOT OK");
    end
    $finish;
  end

  initial begin
    #3000000;
    $display("tb_accel_magnitude_change_alarm_unit NOT OK");
    $finish;
  end

endmodule

[files.f]
design/amca_pkg.sv
design/amca_ctrl.sv
design/amca_dp.sv
design/accel_magnitude_change_alarm_unit.sv
design/amca_checker.sv
verif/tb_accel_magnitude_change_alarm_unit.sv
